>>> design/wpm_pkg.sv
// Shared constants, command codes and controller-to-datapath types for the wildcard matcher.
package wpm_pkg;

    // Pattern store depth and derived widths.
    localparam int MAX_PATTERN = 64;
    localparam int POS_W       = MAX_PATTERN + 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Star closure runs as a doubling prefix scan, one distance per cycle.
    localparam int CLOSE_STEPS = $clog2(MAX_PATTERN + 1);
    localparam int STEP_W      = (CLOSE_STEPS > 1) ? $clog2(CLOSE_STEPS) : 1;

    // Item field widths.
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;

    // Wildcard characters.
    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

    // Input item commands.
    localparam logic [CMD_W-1:0] CMD_NEW    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd3;

    // Datapath operations issued by the controller.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] DP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] DP_NEW    = 3'd1;
    localparam logic [OP_W-1:0] DP_APPEND = 3'd2;
    localparam logic [OP_W-1:0] DP_STEP   = 3'd3;
    localparam logic [OP_W-1:0] DP_RESULT = 3'd4;
    localparam logic [OP_W-1:0] DP_INIT   = 3'd5;
    localparam logic [OP_W-1:0] DP_CLOSE  = 3'd6;

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

endpackage

>>> design/wpm_ctrl.sv
// Controller state machine: item handshake, closure sequencing and result valid.
module wpm_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [wpm_pkg::CMD_W-1:0]   s_command,
    output logic                        m_valid,
    input  logic                        m_ready,
    output wpm_pkg::dp_cmd_t            dp_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_INIT  = 2'd1;
    localparam logic [1:0] ST_CLOSE = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [wpm_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        accept;
    logic                        out_free;

    // An end-of-text item needs the result slot; other items do not.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && ((s_command != wpm_pkg::CMD_END) || out_free);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // Next state and datapath command.
    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        dp_cmd.op   = wpm_pkg::DP_NOP;
        dp_cmd.step = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_command)
                        wpm_pkg::CMD_NEW: begin
                            dp_cmd.op = wpm_pkg::DP_NEW;
                        end
                        wpm_pkg::CMD_APPEND: begin
                            dp_cmd.op  = wpm_pkg::DP_APPEND;
                            state_next = ST_INIT;
                        end
                        wpm_pkg::CMD_TEXT: begin
                            dp_cmd.op  = wpm_pkg::DP_STEP;
                            state_next = ST_INIT;
                        end
                        default: begin
                            dp_cmd.op  = wpm_pkg::DP_RESULT;
                            state_next = ST_INIT;
                        end
                    endcase
                end
            end
            ST_INIT: begin
                dp_cmd.op  = wpm_pkg::DP_INIT;
                step_next  = '0;
                state_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                dp_cmd.op = wpm_pkg::DP_CLOSE;
                if (step_reg == wpm_pkg::STEP_W'(wpm_pkg::CLOSE_STEPS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set by an end-of-text item, cleared when the item is taken.
    always_comb begin
        if (accept && (s_command == wpm_pkg::CMD_END)) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> design/wpm_datapath.sv
// Datapath: pattern cells, active position bits, star closure scan and result register.
module wpm_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wpm_pkg::dp_cmd_t             dp_cmd,
    input  logic [wpm_pkg::CHAR_W-1:0]   s_character,
    output logic                         m_matched,
    output logic                         m_pattern_too_long
);

    localparam int MAXP = wpm_pkg::MAX_PATTERN;
    localparam logic [wpm_pkg::POS_W-1:0] START_SET = {{MAXP{1'b0}}, 1'b1};

    // One byte per pattern cell; each cell is read only by its own compare.
    logic [wpm_pkg::CHAR_W-1:0] pattern_reg [MAXP];

    logic [wpm_pkg::LEN_W-1:0] len_reg, len_next;
    logic                      ovf_reg, ovf_next;
    logic [wpm_pkg::POS_W-1:0] act_reg, act_next;
    logic [wpm_pkg::POS_W-1:0] span_reg, span_next;
    logic                      matched_reg, matched_next;
    logic                      too_long_reg, too_long_next;

    logic [MAXP-1:0]           in_use;
    logic [MAXP-1:0]           is_star;
    logic [MAXP-1:0]           is_hit;
    logic [wpm_pkg::POS_W-1:0] step_act;
    logic [wpm_pkg::POS_W-1:0] span_init;
    logic [wpm_pkg::POS_W-1:0] shifted_act;
    logic [wpm_pkg::POS_W-1:0] shifted_span;
    logic                      room;

    assign room = (len_reg < wpm_pkg::LEN_W'(MAXP));

    // Per-cell compares and the consume step from the closed active set.
    always_comb begin
        step_act = '0;
        span_init = '0;
        for (int j = 0; j < MAXP; j++) begin
            in_use[j]  = (wpm_pkg::LEN_W'(j) < len_reg);
            is_star[j] = in_use[j] && (pattern_reg[j] == wpm_pkg::STAR_CHAR);
            is_hit[j]  = in_use[j] && !is_star[j] &&
                         ((pattern_reg[j] == wpm_pkg::ANY_CHAR) ||
                          (pattern_reg[j] == s_character));
            // A star keeps its position; a literal or '?' hit advances one.
            if (act_reg[j] && is_star[j]) begin
                step_act[j] = 1'b1;
            end
            if (act_reg[j] && is_hit[j]) begin
                step_act[j+1] = 1'b1;
            end
            // Position j+1 is reachable from j for free when cell j holds a star.
            span_init[j+1] = is_star[j];
        end
    end

    // Operand shift for the current doubling distance of the closure scan.
    always_comb begin
        shifted_act  = '0;
        shifted_span = '0;
        for (int s = 0; s < wpm_pkg::CLOSE_STEPS; s++) begin
            if (dp_cmd.step == wpm_pkg::STEP_W'(s)) begin
                shifted_act  = act_reg << (1 << s);
                shifted_span = span_reg << (1 << s);
            end
        end
    end

    // Register updates per datapath operation.
    always_comb begin
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        act_next      = act_reg;
        span_next     = span_reg;
        matched_next  = matched_reg;
        too_long_next = too_long_reg;
        case (dp_cmd.op)
            wpm_pkg::DP_NEW: begin
                len_next = '0;
                ovf_next = 1'b0;
                act_next = START_SET;
            end
            wpm_pkg::DP_APPEND: begin
                if (room) begin
                    len_next = len_reg + 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
                act_next = START_SET;
            end
            wpm_pkg::DP_STEP: begin
                act_next = step_act;
            end
            wpm_pkg::DP_RESULT: begin
                matched_next  = act_reg[len_reg] && !ovf_reg;
                too_long_next = ovf_reg;
                act_next      = START_SET;
            end
            wpm_pkg::DP_INIT: begin
                span_next = span_init;
            end
            wpm_pkg::DP_CLOSE: begin
                act_next  = act_reg | (span_reg & shifted_act);
                span_next = span_reg & shifted_span;
            end
            default: begin
            end
        endcase
    end

    // Pattern cell write at the current length.
    always_ff @(posedge aclk) begin
        if ((dp_cmd.op == wpm_pkg::DP_APPEND) && room) begin
            pattern_reg[len_reg[wpm_pkg::ADDR_W-1:0]] <= s_character;
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
            act_reg <= START_SET;
        end else begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
            act_reg <= act_next;
        end
    end

    // Scan and result payload registers.
    always_ff @(posedge aclk) begin
        span_reg     <= span_next;
        matched_reg  <= matched_next;
        too_long_reg <= too_long_next;
    end

    assign m_matched          = matched_reg;
    assign m_pattern_too_long = too_long_reg;

endmodule

>>> design/wildcard_pattern_matcher_core.sv
// Top level of the wildcard pattern matcher: controller, datapath and checks.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  s_      | in        | s_valid / s_ready  | s_command[1:0], s_character[7:0]
//  m_      | out       | m_valid / m_ready  | m_matched, m_pattern_too_long
//
// A new-pattern item is a single update. Append, text and end-of-text items run
// an update, then load the star spans, then one step per doubling distance of
// the star closure scan. The result is registered in the cycle after its
// end-of-text item is taken; the next item is taken while it waits, except
// another end-of-text item.
// Reset is synchronous; the pattern cells need none and no clearing pass runs.
module wildcard_pattern_matcher_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [wpm_pkg::CMD_W-1:0]   s_command,
    input  logic [wpm_pkg::CHAR_W-1:0]  s_character,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_matched,
    output logic                        m_pattern_too_long
);

    wpm_pkg::dp_cmd_t dp_cmd;

    wpm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_cmd    (dp_cmd)
    );

    wpm_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .dp_cmd             (dp_cmd),
        .s_character        (s_character),
        .m_matched          (m_matched),
        .m_pattern_too_long (m_pattern_too_long)
    );

    // Any item other than a new pattern starts the closure scan and blocks input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command != wpm_pkg::CMD_NEW)) |=> !s_ready)
        else $error("input taken while the closure scan was running");

    // An end-of-text item yields a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == wpm_pkg::CMD_END)) |=> m_valid)
        else $error("end-of-text item gave no result");

    // An overflowed pattern never reports a match.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_matched && m_pattern_too_long))
        else $error("match reported for an overflowed pattern");

endmodule

>>> tb/tb_wildcard_pattern_matcher_core.sv
// Self-checking testbench for the wildcard pattern matcher core.
`timescale 1ns / 100ps

module tb_wildcard_pattern_matcher_core;

    localparam int ITEM_TARGET = 750;
    localparam int CALM_AFTER  = 650;
    localparam int TAIL_CYCLES = 24;

    typedef struct packed {
        logic matched;
        logic too_long;
    } verdict_t;

    typedef struct packed {
        logic [wpm_pkg::CMD_W-1:0]  cmd;
        logic [wpm_pkg::CHAR_W-1:0] ch;
        logic [7:0]                 reps;
        logic                       typed;
        logic                       exp_matched;
        logic                       exp_too_long;
    } script_row_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [wpm_pkg::CMD_W-1:0]    s_command;
    logic [wpm_pkg::CHAR_W-1:0]   s_character;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_matched;
    logic                         m_pattern_too_long;

    // Shadow copy of the matcher state.
    logic [wpm_pkg::CHAR_W-1:0]   shadow_pat [0:wpm_pkg::MAX_PATTERN-1];
    int unsigned                  shadow_len;
    logic [wpm_pkg::POS_W-1:0]    shadow_reach;
    logic                         shadow_overflow;

    verdict_t                     verdict_q [$];
    script_row_t                  script [$];
    int                           sent_count;
    int                           mismatch_count;
    bit                           calm;

    wildcard_pattern_matcher_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_character        (s_character),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_pattern_too_long (m_pattern_too_long)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Reached positions after star closure: a reached star also reaches the next position.
    function automatic logic [wpm_pkg::POS_W-1:0] star_closure();
        logic [wpm_pkg::POS_W-1:0] d;
        d = shadow_reach;
        for (int j = 0; j < shadow_len; j++) begin
            if (d[j] && shadow_pat[j] == wpm_pkg::STAR_CHAR) d[j+1] = 1'b1;
        end
        return d;
    endfunction

    // Advance the shadow state by one accepted item and give its verdict, if any.
    task automatic predict_item(input logic [wpm_pkg::CMD_W-1:0] cmd,
                                input logic [wpm_pkg::CHAR_W-1:0] ch,
                                output bit has_verdict, output verdict_t v);
        logic [wpm_pkg::POS_W-1:0] closed;
        logic [wpm_pkg::POS_W-1:0] nxt;
        has_verdict = 1'b0;
        v = '0;
        case (cmd)
            wpm_pkg::CMD_NEW: begin
                shadow_len = 0;
                shadow_overflow = 1'b0;
                shadow_reach = wpm_pkg::POS_W'(1);
            end
            wpm_pkg::CMD_APPEND: begin
                if (shadow_len < wpm_pkg::MAX_PATTERN) begin
                    shadow_pat[shadow_len] = ch;
                    shadow_len++;
                end else begin
                    shadow_overflow = 1'b1;
                end
                shadow_reach = wpm_pkg::POS_W'(1);
            end
            wpm_pkg::CMD_TEXT: begin
                closed = star_closure();
                nxt = '0;
                for (int j = 0; j < shadow_len; j++) begin
                    if (closed[j]) begin
                        if (shadow_pat[j] == wpm_pkg::STAR_CHAR) nxt[j] = 1'b1;
                        else if (shadow_pat[j] == wpm_pkg::ANY_CHAR || shadow_pat[j] == ch)
                            nxt[j+1] = 1'b1;
                    end
                end
                shadow_reach = nxt;
            end
            default: begin
                closed = star_closure();
                has_verdict = 1'b1;
                v.matched = closed[shadow_len] && !shadow_overflow;
                v.too_long = shadow_overflow;
                shadow_reach = wpm_pkg::POS_W'(1);
            end
        endcase
    endtask

    // Present one item, wait for its acceptance, then record what it should produce.
    task automatic send_item(input logic [wpm_pkg::CMD_W-1:0] cmd,
                             input logic [wpm_pkg::CHAR_W-1:0] ch,
                             input bit use_typed, input verdict_t typed);
        bit       has_verdict;
        verdict_t v;
        int       gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_character <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(cmd, ch, has_verdict, v);
        if (has_verdict) verdict_q.push_back(use_typed ? typed : v);
        sent_count++;
        if (sent_count >= CALM_AFTER) calm = 1'b1;
    endtask

    task automatic add_row(input logic [wpm_pkg::CMD_W-1:0] cmd,
                           input logic [wpm_pkg::CHAR_W-1:0] ch,
                           input int reps, input bit typed, input logic m, input logic tl);
        script_row_t row;
        row.cmd = cmd;
        row.ch = ch;
        row.reps = reps[7:0];
        row.typed = typed;
        row.exp_matched = m;
        row.exp_too_long = tl;
        script.push_back(row);
    endtask

    // Mostly a small alphabet with both wildcards, sometimes any byte.
    function automatic logic [wpm_pkg::CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 5))
            0:       return 8'h61;
            1:       return 8'h62;
            2:       return wpm_pkg::STAR_CHAR;
            3:       return wpm_pkg::ANY_CHAR;
            default: return wpm_pkg::CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Stimulus: reset, directed table, then random pattern and text sequences.
    initial begin
        script_row_t                row;
        verdict_t                   typed;
        verdict_t                   none;
        logic [wpm_pkg::CHAR_W-1:0] gen_pat [$];
        logic [wpm_pkg::CHAR_W-1:0] txt [$];
        logic [wpm_pkg::CHAR_W-1:0] c;
        logic [wpm_pkg::CMD_W-1:0]  noise_cmd;
        int                         plen;
        int                         ntext;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = wpm_pkg::CMD_NEW;
        s_character = '0;
        sent_count = 0;
        mismatch_count = 0;
        calm = 1'b0;
        none = '0;
        shadow_len = 0;
        shadow_overflow = 1'b0;
        shadow_reach = wpm_pkg::POS_W'(1);
        for (int j = 0; j < wpm_pkg::MAX_PATTERN; j++) shadow_pat[j] = '0;

        // Empty pattern right after reset: only an empty text matches.
        add_row(wpm_pkg::CMD_END,    8'hFF, 1,  1, 1'b1, 1'b0);
        add_row(wpm_pkg::CMD_TEXT,   8'h00, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_END,    8'h00, 1,  1, 1'b0, 1'b0);
        // Pattern "a*?" against a text with the extreme byte values.
        add_row(wpm_pkg::CMD_NEW,    8'hFF, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_APPEND, 8'h61, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_APPEND, wpm_pkg::STAR_CHAR, 1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_APPEND, wpm_pkg::ANY_CHAR,  1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_TEXT,   8'h61, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_TEXT,   8'hFF, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_TEXT,   8'h00, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_END,    8'h00, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_TEXT,   8'h62, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_END,    8'h00, 1,  0, 1'b0, 1'b0);
        // An append in mid text rearms the text.
        add_row(wpm_pkg::CMD_TEXT,   8'h61, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_APPEND, wpm_pkg::STAR_CHAR, 1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_TEXT,   8'h61, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_TEXT,   8'h78, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_END,    8'h00, 1,  0, 1'b0, 1'b0);
        // A '?' in the text is a literal byte.
        add_row(wpm_pkg::CMD_NEW,    8'h00, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_APPEND, 8'h61, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_TEXT,   wpm_pkg::ANY_CHAR, 1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_END,    8'hFF, 1,  0, 1'b0, 1'b0);
        // Full store of stars, then one append too many, then a fresh empty pattern.
        add_row(wpm_pkg::CMD_NEW,    8'h00, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_APPEND, wpm_pkg::STAR_CHAR, wpm_pkg::MAX_PATTERN, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_END,    8'h00, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_APPEND, 8'h55, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_END,    8'h00, 1,  1, 1'b0, 1'b1);
        add_row(wpm_pkg::CMD_NEW,    8'hAA, 1,  0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_END,    8'h55, 1,  1, 1'b1, 1'b0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[r]) begin
            row = script[r];
            typed.matched = row.exp_matched;
            typed.too_long = row.exp_too_long;
            repeat (row.reps) send_item(row.cmd, row.ch, row.typed, typed);
        end

        // Random part: a pattern, then a few texts, mostly built to match it.
        while (sent_count < ITEM_TARGET) begin
            send_item(wpm_pkg::CMD_NEW, wpm_pkg::CHAR_W'($urandom_range(0, 255)), 0, none);
            gen_pat.delete();
            plen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 8);
            for (int i = 0; i < plen; i++) begin
                c = pick_char();
                send_item(wpm_pkg::CMD_APPEND, c, 0, none);
                if (gen_pat.size() < wpm_pkg::MAX_PATTERN) gen_pat.push_back(c);
            end
            ntext = $urandom_range(1, 4);
            repeat (ntext) begin
                txt.delete();
                if ($urandom_range(0, 2) != 0) begin
                    foreach (gen_pat[k]) begin
                        if (gen_pat[k] == wpm_pkg::STAR_CHAR)
                            repeat ($urandom_range(0, 2)) txt.push_back(pick_char());
                        else if (gen_pat[k] == wpm_pkg::ANY_CHAR)
                            txt.push_back(pick_char());
                        else
                            txt.push_back(gen_pat[k]);
                    end
                    // Sometimes spoil one byte of the matching text.
                    if (txt.size() > 0 && $urandom_range(0, 3) == 0)
                        txt[$urandom_range(0, txt.size() - 1)] = pick_char();
                end else begin
                    repeat ($urandom_range(0, 6)) txt.push_back(pick_char());
                end
                foreach (txt[k]) begin
                    if ($urandom_range(0, 24) == 0) begin
                        c = pick_char();
                        send_item(wpm_pkg::CMD_APPEND, c, 0, none);
                        if (gen_pat.size() < wpm_pkg::MAX_PATTERN) gen_pat.push_back(c);
                    end
                    if ($urandom_range(0, 29) == 0) begin
                        noise_cmd = wpm_pkg::CMD_W'($urandom_range(0, 3));
                        send_item(noise_cmd, wpm_pkg::CHAR_W'($urandom_range(0, 255)), 0, none);
                    end
                    send_item(wpm_pkg::CMD_TEXT, txt[k], 0, none);
                end
                send_item(wpm_pkg::CMD_END, wpm_pkg::CHAR_W'($urandom_range(0, 255)), 0, none);
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding verdicts, then let the pipeline settle.
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Result side: runs of ready broken by stall bursts until the quiet final stretch.
    initial begin : result_sink
        int run_len;
        int stall_len;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            run_len = $urandom_range(4, 60);
            repeat (run_len) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
            if (!calm) begin
                stall_len = $urandom_range(1, 13);
                repeat (stall_len) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
        end
    end

    // Compare every accepted result with the oldest outstanding verdict.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected result item: matched %0d, pattern_too_long %0d",
                       m_matched, m_pattern_too_long);
                mismatch_count++;
            end else begin
                want = verdict_q.pop_front();
                if (m_matched !== want.matched) begin
                    $error("matched: expected %0d, actual %0d", want.matched, m_matched);
                    mismatch_count++;
                end
                if (m_pattern_too_long !== want.too_long) begin
                    $error("pattern_too_long: expected %0d, actual %0d",
                           want.too_long, m_pattern_too_long);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog in case the handshake hangs.
    initial begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> wildcard_pattern_matcher_core.f
design/wpm_pkg.sv
design/wpm_ctrl.sv
design/wpm_datapath.sv
design/wildcard_pattern_matcher_core.sv
tb/tb_wildcard_pattern_matcher_core.sv
